@@ sv/assert_macros.svh @@
// Assertion macros used by the RTL of the mean removal block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside of reset.
`define BMR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define BMR_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ sv/bmr_pkg.sv @@
// Package of types and constants for the buffer mean removal block.
`default_nettype none

package bmr_pkg;

    // Field widths
    localparam int SAMPLE_W = 16;
    localparam int SUM_W    = 23;
    localparam int MAG_W    = SUM_W - 1;
    localparam int MEAN_W   = SAMPLE_W + 1;
    localparam int DIFF_W   = SAMPLE_W + 2;

    // Buffer depth default
    localparam int DEF_BUFFER_DEPTH = 64;

    // Saturation bounds
    localparam logic signed [DIFF_W-1:0]   DIFF_MAX = DIFF_W'(32767);
    localparam logic signed [DIFF_W-1:0]   DIFF_MIN = -DIFF_W'(32768);
    localparam logic signed [SAMPLE_W-1:0] SAT_MAX  = SAMPLE_W'(32767);
    localparam logic signed [SAMPLE_W-1:0] SAT_MIN  = SAMPLE_W'(32768);

    // Control states
    typedef enum logic [1:0] {
        ST_LOAD,
        ST_DIV,
        ST_READ
    } t_state;

endpackage

`default_nettype wire

@@ sv/bmr_if.sv @@
// Valid/ready channel interfaces for sample input and output items.
`default_nettype none

interface bmr_in_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [bmr_pkg::SAMPLE_W-1:0]   sample_in;
    logic                                  last_in;

    modport source (output valid, output sample_in, output last_in, input ready);
    modport sink   (input valid, input sample_in, input last_in, output ready);
endinterface

interface bmr_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [bmr_pkg::SAMPLE_W-1:0]   sample_out;
    logic                                  last_out;

    modport source (output valid, output sample_out, output last_out, input ready);
    modport sink   (input valid, input sample_out, input last_out, output ready);
endinterface

`default_nettype wire

@@ sv/buffer_mean_removal.sv @@
// Top level of the buffer mean removal block: store, divide and readout.
`default_nettype none
`include "assert_macros.svh"

// Buffer mean removal. Samples enter one per cycle on i_smp while the block is
// loading and are written to a 64-entry (BUFFER_DEPTH) sample memory while a
// running sum accumulates. A buffer closes on a sample with last_in set or when
// the memory is full. The block then stops taking items and runs a restoring
// divider, one quotient bit per cycle: a load step, then 22 shift-subtract
// steps. Readout follows: each stored sample minus the truncated mean,
// saturated to 16 bits, leaves on o_smp through the registered memory read and
// the output register; a new read is issued only once the previous one has
// landed and the output register is free or being taken. last_out marks the
// final item. Input is taken again in the cycle after the final read lands,
// while that last item may still wait in the output register.
module buffer_mean_removal #(
    parameter int BUFFER_DEPTH = bmr_pkg::DEF_BUFFER_DEPTH
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    bmr_in_if.sink     i_smp,
    bmr_out_if.source  o_smp
);
    import bmr_pkg::*;

    localparam int CW  = $clog2(BUFFER_DEPTH + 1);
    localparam int AW  = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int DCW = $clog2(MAG_W + 1);

    // Sample memory
    logic signed [SAMPLE_W-1:0] r_mem [BUFFER_DEPTH];

    // Control and datapath registers
    t_state                     r_state, n_state;
    logic [CW-1:0]              r_fill;
    logic signed [SUM_W-1:0]    r_sum;
    logic [DCW-1:0]             r_div_cnt;
    logic [CW-1:0]              r_rem;
    logic [MAG_W-1:0]           r_quo;
    logic                       r_neg;
    logic signed [MEAN_W-1:0]   r_mean;
    logic [CW-1:0]              r_rd_addr;
    logic                       r_rd_pend;
    logic                       r_rd_last;
    logic signed [SAMPLE_W-1:0] r_rd_data;
    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_sample;
    logic                       r_out_last;

    // Combinational signals
    logic                       in_ready;
    logic                       in_acc;
    logic                       close_buf;
    logic                       div_done;
    logic                       rd_issue;
    logic [CW-1:0]              fill_inc;
    logic signed [SUM_W-1:0]    sum_inc;
    logic [SUM_W-1:0]           sum_abs;
    logic [CW:0]                rem_sh;
    logic [CW:0]                div_ext;
    logic                       rem_ge;
    logic [CW:0]                rem_sub;
    logic [CW-1:0]              rem_nx;
    logic [MAG_W-1:0]           quo_nx;
    logic [SUM_W-1:0]           mean_full;
    logic signed [DIFF_W-1:0]   diff;
    logic signed [SAMPLE_W-1:0] sat_val;

    // Input accumulation
    assign in_acc    = i_smp.valid && in_ready;
    assign fill_inc  = r_fill + CW'(1);
    assign sum_inc   = r_sum + SUM_W'(i_smp.sample_in);
    assign close_buf = in_acc && (i_smp.last_in || (fill_inc == CW'(BUFFER_DEPTH)));

    // Divider step: magnitude of the sum divided by the sample count
    assign sum_abs   = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
    assign rem_sh    = {r_rem, r_quo[MAG_W-1]};
    assign div_ext   = {1'b0, r_fill};
    assign rem_ge    = (rem_sh >= div_ext);
    assign rem_sub   = rem_sh - div_ext;
    assign rem_nx    = rem_ge ? rem_sub[CW-1:0] : rem_sh[CW-1:0];
    assign quo_nx    = {r_quo[MAG_W-2:0], rem_ge};
    assign mean_full = r_neg ? (SUM_W'(0) - {1'b0, quo_nx}) : {1'b0, quo_nx};
    assign div_done  = (r_state == ST_DIV) && (r_div_cnt == DCW'(MAG_W));

    // Difference and saturation of a sample read back
    assign diff = DIFF_W'(r_rd_data) - DIFF_W'(r_mean);
    always_comb begin
        if (diff > DIFF_MAX) begin
            sat_val = SAT_MAX;
        end else if (diff < DIFF_MIN) begin
            sat_val = SAT_MIN;
        end else begin
            sat_val = diff[SAMPLE_W-1:0];
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD: begin
                if (close_buf) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                if (r_rd_pend && r_rd_last) begin
                    n_state = ST_LOAD;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    // State outputs
    always_comb begin
        in_ready = 1'b0;
        rd_issue = 1'b0;
        case (r_state)
            ST_LOAD: begin
                in_ready = 1'b1;
            end
            ST_DIV: begin
                in_ready = 1'b0;
            end
            ST_READ: begin
                rd_issue = (r_rd_addr != r_fill) && !r_rd_pend
                           && (!r_out_valid || o_smp.ready);
            end
            default: begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign i_smp.ready      = in_ready;
    assign o_smp.valid      = r_out_valid;
    assign o_smp.sample_out = r_out_sample;
    assign o_smp.last_out   = r_out_last;

    // Memory write port
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mem[r_fill[AW-1:0]] <= i_smp.sample_in;
        end
    end

    // Memory read port, registered
    always_ff @(posedge i_clk) begin
        if (rd_issue) begin
            r_rd_data <= r_mem[r_rd_addr[AW-1:0]];
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_fill      <= '0;
            r_sum       <= '0;
            r_div_cnt   <= '0;
            r_rd_addr   <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_pend <= rd_issue;
            if (in_acc) begin
                r_fill <= fill_inc;
                r_sum  <= sum_inc;
            end
            if (close_buf) begin
                r_div_cnt <= '0;
            end else if (r_state == ST_DIV) begin
                r_div_cnt <= r_div_cnt + DCW'(1);
            end
            if (div_done) begin
                r_rd_addr <= '0;
            end else if (rd_issue) begin
                r_rd_addr <= r_rd_addr + CW'(1);
            end
            if (r_rd_pend && r_rd_last) begin
                r_fill <= '0;
                r_sum  <= '0;
            end
            if (r_rd_pend) begin
                r_out_valid <= 1'b1;
            end else if (o_smp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Divider and output payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == ST_DIV) begin
            if (r_div_cnt == '0) begin
                r_quo <= sum_abs[MAG_W-1:0];
                r_rem <= '0;
                r_neg <= r_sum[SUM_W-1];
            end else begin
                r_quo <= quo_nx;
                r_rem <= rem_nx;
            end
        end
        if (div_done) begin
            r_mean <= mean_full[MEAN_W-1:0];
        end
        if (rd_issue) begin
            r_rd_last <= (r_rd_addr + CW'(1)) == r_fill;
        end
        if (r_rd_pend) begin
            r_out_sample <= sat_val;
            r_out_last   <= r_rd_last;
        end
    end

    // Checks
    `BMR_ASSERT(a_pend_in_read, r_rd_pend |-> (r_state == ST_READ), "read outside readout")
    `BMR_ASSERT(a_pend_out_free, r_rd_pend |-> !r_out_valid, "read data lands on full output")
    `BMR_ASSERT(a_fill_bound, r_fill <= CW'(BUFFER_DEPTH), "fill count beyond depth")
    `BMR_ASSERT(a_last_load, (r_rd_pend && r_rd_last) |=> (r_state == ST_LOAD), "load not resumed")
    `BMR_ASSERT(a_last_clears, (r_rd_pend && r_rd_last) |=> (r_fill == '0), "buffer not cleared")
    `BMR_ASSERT_ALWAYS(a_no_read_in_reset, !i_rst_n |=> !r_rd_pend, "read pending after reset")

endmodule

`default_nettype wire

@@ tb/sv/bmr_checker.sv @@
`timescale 1ns / 1ps
// Checker for the buffer mean removal block: predicts centered samples and compares.
module bmr_checker #(
    parameter int BUFFER_DEPTH = bmr_pkg::DEF_BUFFER_DEPTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_ready,
    input  logic signed [bmr_pkg::SAMPLE_W-1:0] i_in_sample,
    input  logic                                i_in_last,
    input  logic                                i_out_valid,
    input  logic                                i_out_ready,
    input  logic signed [bmr_pkg::SAMPLE_W-1:0] i_out_sample,
    input  logic                                i_out_last,
    output int                                  o_pending,
    output int                                  o_fail_count
);
    import bmr_pkg::*;

    // Quiet down after this many printed mismatches; counting goes on
    localparam int PRINT_CAP = 200;

    // One centered sample as it should leave the block
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } t_centered;

    // Own copy of the buffer state
    logic signed [SAMPLE_W-1:0] held [BUFFER_DEPTH];
    logic [6:0]                 held_count;
    logic signed [SUM_W-1:0]    held_sum;

    // Centered samples waiting to come out, oldest first
    t_centered centered_q [$];
    int        result_index;

    task automatic report_mismatch(input string msg);
        if (o_fail_count < PRINT_CAP) begin
            $display("MISMATCH @%0t: %s", $time, msg);
        end
        o_fail_count++;
    endtask

    // Store a sample; when the buffer closes, queue every sample minus the mean
    task automatic take_sample(input logic signed [SAMPLE_W-1:0] smp, input logic lst);
        int        mean;
        int        diff;
        int        k;
        t_centered item;
        held[held_count] = smp;
        held_count = held_count + 7'd1;
        held_sum = held_sum + smp;
        if (lst || held_count == BUFFER_DEPTH) begin
            // integer division truncates toward zero
            mean = int'(held_sum) / int'(held_count);
            for (k = 0; k < held_count; k++) begin
                diff = int'(held[k]) - mean;
                if (diff > int'(SAT_MAX)) begin
                    diff = int'(SAT_MAX);
                end else if (diff < int'(SAT_MIN)) begin
                    diff = int'(SAT_MIN);
                end
                item.sample = SAMPLE_W'(diff);
                item.last = (k == int'(held_count) - 1);
                centered_q.push_back(item);
            end
            held_count = '0;
            held_sum = '0;
        end
    endtask

    task automatic check_result(input logic signed [SAMPLE_W-1:0] got_sample,
                                input logic got_last);
        t_centered want;
        if (centered_q.size() == 0) begin
            report_mismatch($sformatf("result %0d unexpected: sample_out %0d last_out %0b",
                                      result_index, got_sample, got_last));
        end else begin
            want = centered_q.pop_front();
            if (got_sample !== want.sample) begin
                report_mismatch($sformatf("result %0d sample_out %0d, want %0d",
                                          result_index, got_sample, want.sample));
            end
            if (got_last !== want.last) begin
                report_mismatch($sformatf("result %0d last_out %0b, want %0b",
                                          result_index, got_last, want.last));
            end
        end
        result_index++;
    endtask

    // Watch both channels at the rising edge; output first, it drains older buffers
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            held_count = '0;
            held_sum = '0;
            centered_q.delete();
            result_index = 0;
            o_pending = 0;
            o_fail_count = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                check_result(i_out_sample, i_out_last);
            end
            if (i_in_valid && i_in_ready) begin
                take_sample(i_in_sample, i_in_last);
            end
            o_pending = centered_q.size();
        end
    end

endmodule

@@ tb/sv/tb_buffer_mean_removal.sv @@
`timescale 1ns / 1ps
// Testbench top for the buffer mean removal block: clock, reset, stimulus and verdict.
module tb_buffer_mean_removal;
    import bmr_pkg::*;

    localparam int BUFFER_DEPTH = DEF_BUFFER_DEPTH;
    localparam int ITEM_COUNT   = 320;
    localparam int HOLD_OFF     = 400;
    localparam int DRAIN_CYCLES = 64;
    localparam int LIMIT_CYCLES = 200000;

    // How the samples of one buffer are made up
    typedef enum int {
        FILL_RANDOM,
        FILL_OFFSET,
        FILL_EXTREME
    } t_fill;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    int   cycle_count = 0;
    int   pending;
    int   fail_count;
    int   random_sent;

    bmr_in_if  smp_in ();
    bmr_out_if smp_out ();

    buffer_mean_removal #(
        .BUFFER_DEPTH(BUFFER_DEPTH)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_smp  (smp_in),
        .o_smp  (smp_out)
    );

    bmr_checker #(
        .BUFFER_DEPTH(BUFFER_DEPTH)
    ) i_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (smp_in.valid),
        .i_in_ready  (smp_in.ready),
        .i_in_sample (smp_in.sample_in),
        .i_in_last   (smp_in.last_in),
        .i_out_valid (smp_out.valid),
        .i_out_ready (smp_out.ready),
        .i_out_sample(smp_out.sample_out),
        .i_out_last  (smp_out.last_out),
        .o_pending   (pending),
        .o_fail_count(fail_count)
    );

    // 100 MHz clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Hard stop
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    // Idle length: mostly none, often short, now and then long
    function automatic int idle_span();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_sample(input t_fill pattern,
                                                                input int dc);
        int v;
        case (pattern)
            FILL_OFFSET: begin
                // DC level plus small noise, clipped to the sample range
                v = int'($urandom_range(0, 1024)) - 512 + dc;
                if (v > int'(SAT_MAX)) v = int'(SAT_MAX);
                if (v < int'(SAT_MIN)) v = int'(SAT_MIN);
                return SAMPLE_W'(v);
            end
            FILL_EXTREME: begin
                case ($urandom_range(0, 3))
                    0: return SAT_MIN;
                    1: return SAT_MAX;
                    2: return '0;
                    default: return '1;
                endcase
            end
            default: return SAMPLE_W'($urandom());
        endcase
    endfunction

    // Offer one item after an optional gap and hold it until the block takes it
    task automatic offer_sample(input logic signed [SAMPLE_W-1:0] smp, input logic lst,
                                input int gap);
        @(negedge i_clk);
        if (gap > 0) begin
            smp_in.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        smp_in.valid     <= 1'b1;
        smp_in.sample_in <= smp;
        smp_in.last_in   <= lst;
        @(posedge i_clk);
        while (!smp_in.ready) @(posedge i_clk);
    endtask

    // One whole buffer; a full one may close with or without the last mark
    task automatic send_buffer(input int len, input t_fill pattern, input logic mark_full,
                               input logic steady);
        int   dc;
        int   k;
        logic lst;
        dc = int'($urandom_range(0, 65535)) - 32768;
        for (k = 0; k < len; k++) begin
            lst = 1'b0;
            if (k == len - 1) begin
                lst = (len == BUFFER_DEPTH) ? mark_full : 1'b1;
            end
            offer_sample(pick_sample(pattern, dc), lst, steady ? 0 : idle_span());
            random_sent++;
        end
    endtask

    // Receiver: random stalls, one long hold-off to back the block up
    initial begin : drain_side
        int burst_no;
        int stall;
        smp_out.ready = 1'b0;
        burst_no = 0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            burst_no++;
            stall = (burst_no == 20) ? HOLD_OFF : idle_span();
            if (stall > 0) begin
                smp_out.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            smp_out.ready <= 1'b1;
            repeat (($urandom_range(0, 4) == 0) ? $urandom_range(20, 100)
                                                : $urandom_range(1, 8)) @(negedge i_clk);
        end
    end

    // Sender: reset, directed buffers, random buffers, drain and verdict
    initial begin : stimulus
        int    r;
        int    len;
        t_fill pattern;
        smp_in.valid     = 1'b0;
        smp_in.sample_in = '0;
        smp_in.last_in   = 1'b0;
        random_sent      = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Single-sample buffers at both extremes: output is zero
        offer_sample(SAT_MAX, 1'b1, idle_span());
        offer_sample(SAT_MIN, 1'b1, idle_span());
        // Large negative mean pushes the positive sample past the top
        offer_sample(SAT_MAX, 1'b0, idle_span());
        offer_sample(SAT_MIN, 1'b0, idle_span());
        offer_sample(SAT_MIN, 1'b0, idle_span());
        offer_sample(SAT_MIN, 1'b1, idle_span());
        // Large positive mean pushes the negative sample past the bottom
        offer_sample(SAT_MIN, 1'b0, idle_span());
        offer_sample(SAT_MAX, 1'b0, idle_span());
        offer_sample(SAT_MAX, 1'b0, idle_span());
        offer_sample(SAT_MAX, 1'b1, idle_span());
        // Odd sums: mean rounds toward zero on both signs
        offer_sample(-16'sd3, 1'b0, idle_span());
        offer_sample(-16'sd2, 1'b1, idle_span());
        offer_sample(16'sd3, 1'b0, 0);
        offer_sample(16'sd2, 1'b1, 0);
        // Small values around zero
        offer_sample(16'sd0, 1'b0, 0);
        offer_sample(-16'sd1, 1'b0, 0);
        offer_sample(16'sd1, 1'b0, 0);
        offer_sample(16'sd0, 1'b1, 0);

        // Full buffers, closed by depth alone and by depth plus the last mark
        send_buffer(BUFFER_DEPTH, FILL_OFFSET, 1'b0, 1'b0);
        send_buffer(BUFFER_DEPTH, FILL_RANDOM, 1'b1, 1'b1);

        // Random buffers: mostly short, some single, some full
        while (random_sent < ITEM_COUNT) begin
            r = $urandom_range(0, 99);
            if (r < 10) begin
                len = BUFFER_DEPTH;
            end else if (r < 20) begin
                len = 1;
            end else if (r < 85) begin
                len = $urandom_range(2, 16);
            end else begin
                len = $urandom_range(17, BUFFER_DEPTH - 1);
            end
            pattern = t_fill'($urandom_range(0, 2));
            send_buffer(len, pattern, 1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0);
        end

        @(negedge i_clk);
        smp_in.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
